// ===== rtl/md5_pkg.sv =====
// MD5 package: state and block-mode types, initial chaining value and round tables.
// No dependencies; used by md5_round and md5_message_digest.
`timescale 1ns / 1ps

package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRE,
        S_RUN,
        S_ADD
    } t_state;

    // Source of the 64 bytes compressed in one pass
    typedef enum logic [1:0] {
        M_FULL,   // buffer only
        M_PAD1,   // buffer, 0x80, zeros; no length
        M_PAD2,   // zeros and length
        M_FINAL   // buffer, 0x80, zeros and length
    } t_mode;

    function automatic logic [31:0] round_const(input logic [5:0] r);
        case (r)
            6'd0:  round_const = 32'hd76aa478;  6'd1:  round_const = 32'he8c7b756;
            6'd2:  round_const = 32'h242070db;  6'd3:  round_const = 32'hc1bdceee;
            6'd4:  round_const = 32'hf57c0faf;  6'd5:  round_const = 32'h4787c62a;
            6'd6:  round_const = 32'ha8304613;  6'd7:  round_const = 32'hfd469501;
            6'd8:  round_const = 32'h698098d8;  6'd9:  round_const = 32'h8b44f7af;
            6'd10: round_const = 32'hffff5bb1;  6'd11: round_const = 32'h895cd7be;
            6'd12: round_const = 32'h6b901122;  6'd13: round_const = 32'hfd987193;
            6'd14: round_const = 32'ha679438e;  6'd15: round_const = 32'h49b40821;
            6'd16: round_const = 32'hf61e2562;  6'd17: round_const = 32'hc040b340;
            6'd18: round_const = 32'h265e5a51;  6'd19: round_const = 32'he9b6c7aa;
            6'd20: round_const = 32'hd62f105d;  6'd21: round_const = 32'h02441453;
            6'd22: round_const = 32'hd8a1e681;  6'd23: round_const = 32'he7d3fbc8;
            6'd24: round_const = 32'h21e1cde6;  6'd25: round_const = 32'hc33707d6;
            6'd26: round_const = 32'hf4d50d87;  6'd27: round_const = 32'h455a14ed;
            6'd28: round_const = 32'ha9e3e905;  6'd29: round_const = 32'hfcefa3f8;
            6'd30: round_const = 32'h676f02d9;  6'd31: round_const = 32'h8d2a4c8a;
            6'd32: round_const = 32'hfffa3942;  6'd33: round_const = 32'h8771f681;
            6'd34: round_const = 32'h6d9d6122;  6'd35: round_const = 32'hfde5380c;
            6'd36: round_const = 32'ha4beea44;  6'd37: round_const = 32'h4bdecfa9;
            6'd38: round_const = 32'hf6bb4b60;  6'd39: round_const = 32'hbebfbc70;
            6'd40: round_const = 32'h289b7ec6;  6'd41: round_const = 32'heaa127fa;
            6'd42: round_const = 32'hd4ef3085;  6'd43: round_const = 32'h04881d05;
            6'd44: round_const = 32'hd9d4d039;  6'd45: round_const = 32'he6db99e5;
            6'd46: round_const = 32'h1fa27cf8;  6'd47: round_const = 32'hc4ac5665;
            6'd48: round_const = 32'hf4292244;  6'd49: round_const = 32'h432aff97;
            6'd50: round_const = 32'hab9423a7;  6'd51: round_const = 32'hfc93a039;
            6'd52: round_const = 32'h655b59c3;  6'd53: round_const = 32'h8f0ccc92;
            6'd54: round_const = 32'hffeff47d;  6'd55: round_const = 32'h85845dd1;
            6'd56: round_const = 32'h6fa87e4f;  6'd57: round_const = 32'hfe2ce6e0;
            6'd58: round_const = 32'ha3014314;  6'd59: round_const = 32'h4e0811a1;
            6'd60: round_const = 32'hf7537e82;  6'd61: round_const = 32'hbd3af235;
            6'd62: round_const = 32'h2ad7d2bb;  6'd63: round_const = 32'heb86d391;
            default: round_const = 32'h0;
        endcase
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used in round r; the multipliers only matter mod 16
    function automatic logic [3:0] msg_idx(input logic [5:0] r);
        logic [3:0] q;
        logic [3:0] k;
        q = r[3:0];
        case (r[5:4])
            2'd0: k = q;
            2'd1: k = 4'(q * 4'd5 + 4'd1);
            2'd2: k = 4'(q * 4'd3 + 4'd5);
            2'd3: k = 4'(q * 4'd7);
            default: k = q;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/md5_message_digest.sv =====
// MD5 digest engine top level: byte intake, block buffer RAM, padding, round sequencer.
// Depends on md5_pkg and md5_round.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_valid/o_ready): one item per message byte, i_has_byte set,
//   i_last set on the final item. An item with i_last and no byte ends the message
//   as received so far (empty message if nothing came before).
//   Output channel (o_valid/i_ready): one item per message, the four chaining words;
//   each word gives its four digest bytes little-endian.
//   Bytes are written into a 16 x 32-bit buffer RAM with byte lanes. Byte items
//   are taken one per cycle until the 64th byte of a block; the block is then
//   compressed (one RAM prefetch, 64 rounds at one per cycle through the round
//   unit, one chaining add), during which o_ready is low.
//   A last item's result takes one compression pass, or two when 56 or more bytes
//   sit in the buffer (an extra padding block), plus one more if its byte completed a block.
//   Padding bytes and the bit length are merged into the RAM read data, so the
//   buffer is never cleared.
//   The result sits in an output register; new bytes are accepted while it waits.
//   A following message's final add waits until that register is free.
//   Reset (synchronous, i_rst_n low) loads the initial chaining value, clears the
//   byte count and drops o_valid; buffer contents are left as they are.

module md5_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_a,
    output logic [31:0] o_digest_b,
    output logic [31:0] o_digest_c,
    output logic [31:0] o_digest_d
);

    md5_pkg::t_state r_state, n_state;
    md5_pkg::t_mode  r_mode, n_mode;
    logic [63:0]     r_cnt, n_cnt;
    logic            r_last, n_last;
    logic            r_ovalid, n_ovalid;

    logic [31:0] mem [16];
    logic [31:0] r_rdata;
    logic [3:0]  r_k;
    logic [3:0]  rd_addr;

    logic [5:0]  r_rnd;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_h [4];
    logic [31:0] r_out [4];
    logic [31:0] word;
    logic [31:0] b_next;
    logic [63:0] bits;
    logic [63:0] cnt_inc;

    logic acc;
    logic out_free;
    logic done;

    assign acc      = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign cnt_inc  = r_cnt + 64'(i_has_byte);
    assign bits     = {r_cnt[60:0], 3'b000};

    function automatic md5_pkg::t_mode pad_mode(input logic [5:0] pos);
        return (pos[5:3] == 3'b111) ? md5_pkg::M_PAD1 : md5_pkg::M_FINAL;
    endfunction

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= md5_pkg::S_IDLE;
            r_mode   <= md5_pkg::M_FULL;
            r_cnt    <= 64'd0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_cnt    <= n_cnt;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_ovalid = r_ovalid && !i_ready;
        o_ready  = 1'b0;
        done     = 1'b0;
        case (r_state)
            md5_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (acc) begin
                    n_cnt  = cnt_inc;
                    n_last = i_last;
                    if (i_has_byte && r_cnt[5:0] == 6'h3f) begin
                        n_mode  = md5_pkg::M_FULL;
                        n_state = md5_pkg::S_PRE;
                    end else if (i_last) begin
                        n_mode  = pad_mode(cnt_inc[5:0]);
                        n_state = md5_pkg::S_PRE;
                    end
                end
            end
            md5_pkg::S_PRE: n_state = md5_pkg::S_RUN;
            md5_pkg::S_RUN: begin
                if (r_rnd == 6'h3f) begin
                    n_state = md5_pkg::S_ADD;
                end
            end
            md5_pkg::S_ADD: begin
                case (r_mode)
                    md5_pkg::M_FULL: begin
                        if (r_last) begin
                            n_mode  = pad_mode(r_cnt[5:0]);
                            n_state = md5_pkg::S_PRE;
                        end else begin
                            n_state = md5_pkg::S_IDLE;
                        end
                    end
                    md5_pkg::M_PAD1: begin
                        n_mode  = md5_pkg::M_PAD2;
                        n_state = md5_pkg::S_PRE;
                    end
                    default: begin
                        // final block: wait for the output register
                        if (out_free) begin
                            done     = 1'b1;
                            n_ovalid = 1'b1;
                            n_cnt    = 64'd0;
                            n_last   = 1'b0;
                            n_state  = md5_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            default: n_state = md5_pkg::S_IDLE;
        endcase
    end

    // ---------------- block buffer RAM ----------------
    assign rd_addr = (r_state == md5_pkg::S_RUN) ? md5_pkg::msg_idx(r_rnd + 6'd1)
                                                 : md5_pkg::msg_idx(6'd0);

    always_ff @(posedge i_clk) begin
        if (acc && i_has_byte) begin
            mem[r_cnt[5:2]][{r_cnt[1:0], 3'b000} +: 8] <= i_data_byte;
        end
        r_rdata <= mem[rd_addr];
        r_k     <= rd_addr;
    end

    // padding and length merged into the word read back
    always_comb begin
        logic [5:0] idx;
        logic [7:0] mb;
        logic [7:0] pb;
        word = 32'h0;
        for (int j = 0; j < 4; j++) begin
            idx = {r_k, 2'(j)};
            mb  = r_rdata[8*j +: 8];
            if (idx < r_cnt[5:0]) begin
                pb = mb;
            end else if (idx == r_cnt[5:0]) begin
                pb = md5_pkg::PAD_BYTE;
            end else begin
                pb = 8'h00;
            end
            case (r_mode)
                md5_pkg::M_FULL:  word[8*j +: 8] = mb;
                md5_pkg::M_PAD1:  word[8*j +: 8] = pb;
                md5_pkg::M_PAD2:  word[8*j +: 8] = (idx[5:3] == 3'b111)
                                                   ? bits[{idx[2:0], 3'b000} +: 8] : 8'h00;
                md5_pkg::M_FINAL: word[8*j +: 8] = (idx[5:3] == 3'b111)
                                                   ? bits[{idx[2:0], 3'b000} +: 8] : pb;
                default:          word[8*j +: 8] = 8'h00;
            endcase
        end
    end

    md5_round u_round (
        .i_rnd    (r_rnd),
        .i_a      (r_a),
        .i_b      (r_b),
        .i_c      (r_c),
        .i_d      (r_d),
        .i_word   (word),
        .o_b_next (b_next)
    );

    // ---------------- working words and chaining value ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h[0] <= md5_pkg::IV_A;
            r_h[1] <= md5_pkg::IV_B;
            r_h[2] <= md5_pkg::IV_C;
            r_h[3] <= md5_pkg::IV_D;
            r_rnd  <= 6'd0;
        end else begin
            case (r_state)
                md5_pkg::S_PRE: begin
                    r_rnd <= 6'd0;
                    r_a   <= r_h[0];
                    r_b   <= r_h[1];
                    r_c   <= r_h[2];
                    r_d   <= r_h[3];
                end
                md5_pkg::S_RUN: begin
                    r_rnd <= r_rnd + 6'd1;
                    r_a   <= r_d;
                    r_b   <= b_next;
                    r_c   <= r_b;
                    r_d   <= r_c;
                end
                md5_pkg::S_ADD: begin
                    if (done) begin
                        r_out[0] <= r_h[0] + r_a;
                        r_out[1] <= r_h[1] + r_b;
                        r_out[2] <= r_h[2] + r_c;
                        r_out[3] <= r_h[3] + r_d;
                        r_h[0]   <= md5_pkg::IV_A;
                        r_h[1]   <= md5_pkg::IV_B;
                        r_h[2]   <= md5_pkg::IV_C;
                        r_h[3]   <= md5_pkg::IV_D;
                    end else if (r_mode == md5_pkg::M_FULL || r_mode == md5_pkg::M_PAD1) begin
                        r_h[0] <= r_h[0] + r_a;
                        r_h[1] <= r_h[1] + r_b;
                        r_h[2] <= r_h[2] + r_c;
                        r_h[3] <= r_h[3] + r_d;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid    = r_ovalid;
    assign o_digest_a = r_out[0];
    assign o_digest_b = r_out[1];
    assign o_digest_c = r_out[2];
    assign o_digest_d = r_out[3];

    // ---------------- assertions ----------------
    a_word_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == md5_pkg::S_RUN |-> r_k == md5_pkg::msg_idx(r_rnd))
        else $error("buffer word out of step with round");

    a_round_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == md5_pkg::S_RUN && r_rnd != 6'h3f
        |=> r_state == md5_pkg::S_RUN && r_rnd == $past(r_rnd) + 6'd1)
        else $error("round counter skipped");

    a_block_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_has_byte && r_cnt[5:0] == 6'h3f
        |=> r_state == md5_pkg::S_PRE && r_mode == md5_pkg::M_FULL)
        else $error("full block not compressed");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == md5_pkg::S_ADD
            && ($past(r_mode) == md5_pkg::M_PAD2 || $past(r_mode) == md5_pkg::M_FINAL))
        else $error("result raised outside a final block");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> !r_ovalid || i_ready)
        else $error("result register overwritten");

endmodule

// ===== rtl/md5_round.sv =====
// MD5 single round: boolean function, additions and rotation giving the new b word.
// Uses md5_pkg for the round constant and rotation tables.
`timescale 1ns / 1ps

module md5_round (
    input  logic [5:0]  i_rnd,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_word,
    output logic [31:0] o_b_next
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot;

    always_comb begin
        case (i_rnd[5:4])
            2'd0: f = (i_b & i_c) | (~i_b & i_d);
            2'd1: f = (i_d & i_b) | (~i_d & i_c);
            2'd2: f = i_b ^ i_c ^ i_d;
            2'd3: f = i_c ^ (i_b | ~i_d);
            default: f = 32'h0;
        endcase
    end

    assign sum      = i_a + f + md5_pkg::round_const(i_rnd) + i_word;
    // rotate left: upper half of the doubled word after the shift
    assign rot      = {sum, sum} << md5_pkg::rot_amt(i_rnd);
    assign o_b_next = i_b + rot[63:32];

endmodule
